/* hdl/mms_pkg.sv */
// Shared types and constants for the moving mean-square block.
// No dependencies; imported by every module of the block except mms_ram.
`default_nettype none

package mms_pkg;

    localparam int WIN_W    = 10;   // window register and valid_count width
    localparam int CNT_W    = 11;   // entry count, holds one above the window
    localparam int MEAN_W   = 31;   // avg_power width
    localparam int DATA_W   = 32;   // APB data width
    localparam int ADDR_W   = 3;    // APB address width

    localparam logic [WIN_W-1:0] WIN_RESET = 10'd512;

    // register index, taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_CHECK,
        ST_DROP_RD,
        ST_DROP_SUB,
        ST_DIV,
        ST_DONE
    } back_state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

/* hdl/moving_mean_square.sv */
// Moving-window mean of squared samples.
//
// Channels: sample in (sample, sample_valid, sample_stall) and the result out
// (avg_power, valid_count, result_valid, result_stall). A word moves when
// valid is high and stall is low. win_len is written over APB at
// byte address 0 and should be changed only while the block is idle.
// Each sample is squared in the front end and queued (two entries). The back
// end writes the square into the ring, adds it to the running sum, drops the
// surplus oldest squares, each through ST_CHECK, ST_DROP_RD and ST_DROP_SUB,
// then divides the sum by the count with a restoring divider that yields one
// quotient bit per cycle. The divider runs 41 steps for the default
// SAMPLE_BITS. One sample is worked on at a time; while a result waits on
// result_stall the front end keeps taking samples until its queue and
// squaring register are full, and the back end holds in its final state
// until the result register is free.
// Reset clears pointers, count, sum, queue and result valid and sets
// win_len to 512. Ring contents are not cleared; only written entries are read.
`default_nettype none

module moving_mean_square #(
    parameter int DEPTH       = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [mms_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [mms_pkg::DATA_W-1:0]    pwdata,
    output logic      [mms_pkg::DATA_W-1:0]    prdata,
    output logic                               pready,
    input  wire logic [SAMPLE_BITS-1:0]        sample,
    input  wire logic                          sample_valid,
    output logic                               sample_stall,
    output logic      [mms_pkg::MEAN_W-1:0]    avg_power,
    output logic      [mms_pkg::WIN_W-1:0]     valid_count,
    output logic                               result_valid,
    input  wire logic                          result_stall
);

    import mms_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;

    logic [WIN_W-1:0] window_reg;
    logic             sel_window;
    logic             sq_valid;
    logic [SQ_W-1:0]  sq_data;
    logic             sq_pop;

    assign pready     = 1'b1;
    assign sel_window = (paddr[2] == REG_WINDOW);
    assign prdata     = sel_window ? DATA_W'(window_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg <= WIN_RESET;
        end
        else if (psel && penable && pwrite && pready && sel_window)
        begin
            window_reg <= pwdata[WIN_W-1:0];
        end
    end

    mms_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sq_valid     (sq_valid),
        .sq_data      (sq_data),
        .sq_pop       (sq_pop)
    );

    mms_back #(
        .DEPTH       (DEPTH),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .win_len       (window_reg),
        .sq_valid      (sq_valid),
        .sq_data       (sq_data),
        .sq_pop        (sq_pop),
        .avg_power     (avg_power),
        .valid_count   (valid_count),
        .result_valid  (result_valid),
        .result_stall  (result_stall)
    );

endmodule

`default_nettype wire

/* hdl/mms_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none

module mms_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* hdl/mms_front.sv */
// Front end: accepts samples, squares them and queues the squares.
// Uses mms_pkg.
`default_nettype none

module mms_front #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic [SAMPLE_BITS-1:0]     sample,
    input  wire logic                       sample_valid,
    output logic                            sample_stall,
    output logic                            sq_valid,
    output logic      [2*SAMPLE_BITS-2:0]   sq_data,
    input  wire logic                       sq_pop
);

    import mms_pkg::*;

    localparam int SQ_W = 2 * SAMPLE_BITS - 1;

    logic                   s1_valid_reg, s1_valid_next;
    logic [SAMPLE_BITS-1:0] mag_reg;
    logic [SAMPLE_BITS-1:0] mag;
    logic [2*SAMPLE_BITS-1:0] product;

    logic [SQ_W-1:0] q_mem [2];
    logic            q_wr_ptr_reg, q_rd_ptr_reg;
    logic [1:0]      q_cnt_reg, q_cnt_next;
    logic            q_full;
    logic            accept;
    logic            move;

    assign q_full       = (q_cnt_reg == 2'd2);
    assign sample_stall = s1_valid_reg && q_full;
    assign accept       = sample_valid && !sample_stall;
    assign move         = s1_valid_reg && !q_full;

    // magnitude fits SAMPLE_BITS unsigned, the most negative value included
    assign mag     = sample[SAMPLE_BITS-1] ? (~sample + 1'b1) : sample;
    assign product = mag_reg * mag_reg;

    assign sq_valid = (q_cnt_reg != 2'd0);
    assign sq_data  = q_mem[q_rd_ptr_reg];

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (move)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        q_cnt_next = q_cnt_reg;
        if (move && !sq_pop)
        begin
            q_cnt_next = q_cnt_reg + 2'd1;
        end
        else if (!move && sq_pop)
        begin
            q_cnt_next = q_cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            q_cnt_reg    <= 2'd0;
            q_wr_ptr_reg <= 1'b0;
            q_rd_ptr_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            q_cnt_reg    <= q_cnt_next;
            if (move)
            begin
                q_wr_ptr_reg <= ~q_wr_ptr_reg;
            end
            if (sq_pop)
            begin
                q_rd_ptr_reg <= ~q_rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mag_reg <= mag;
        end
        if (move)
        begin
            q_mem[q_wr_ptr_reg] <= product[SQ_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* hdl/mms_div.sv */
// Restoring divider, one quotient bit per cycle.
// Uses mms_pkg for the status struct.
`default_nettype none

module mms_div #(
    parameter int NUM_W = 41,
    parameter int DEN_W = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [NUM_W-1:0]    dividend,
    input  wire logic [DEN_W-1:0]    divisor,
    output logic      [NUM_W-1:0]    quotient,
    output mms_pkg::div_status_t     status
);

    import mms_pkg::*;

    localparam int STEP_W = $clog2(NUM_W + 1);

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    logic [NUM_W-1:0]  quo_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [DEN_W:0]    shifted;
    logic [DEN_W:0]    diff;
    logic              q_bit;

    assign shifted = {rem_reg, quo_reg[NUM_W-1]};
    assign diff    = shifted - {1'b0, den_reg};
    assign q_bit   = (shifted >= {1'b0, den_reg});

    assign quotient    = quo_reg;
    assign status.busy = busy_reg;
    assign status.done = busy_reg && (step_reg == STEP_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            step_reg <= STEP_W'(NUM_W);
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg - STEP_W'(1);
            if (step_reg == STEP_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], q_bit};
            rem_reg <= q_bit ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
        end
    end

endmodule

`default_nettype wire

/* hdl/mms_back.sv */
// Back end: square ring, running sum, oldest-entry drop and the mean.
// Uses mms_pkg, mms_ram and mms_div.
`default_nettype none

module mms_back #(
    parameter int DEPTH       = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [mms_pkg::WIN_W-1:0]     win_len,
    input  wire logic                          sq_valid,
    input  wire logic [2*SAMPLE_BITS-2:0]      sq_data,
    output logic                               sq_pop,
    output logic      [mms_pkg::MEAN_W-1:0]    avg_power,
    output logic      [mms_pkg::WIN_W-1:0]     valid_count,
    output logic                               result_valid,
    input  wire logic                          result_stall
);

    import mms_pkg::*;

    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W   = SQ_W + WIN_W;
    localparam int PTR_W   = $clog2(DEPTH);
    localparam int WIN_CAP = (DEPTH - 1 < 1023) ? DEPTH - 1 : 1023;

    back_state_t state_reg, state_next;

    logic [SQ_W-1:0]   sq_reg;
    logic [PTR_W-1:0]  newest_reg, oldest_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [SUM_W-1:0]  sum_reg;
    logic [SQ_W-1:0]   ram_rdata;
    logic [SUM_W-1:0]  quotient;
    div_status_t       div_stat;

    logic              result_valid_reg;
    logic [MEAN_W-1:0] mean_reg;
    logic [WIN_W-1:0]  vcount_reg;

    logic [WIN_W-1:0]  win_eff;
    logic              over;
    logic              ram_we, ram_re, div_start, load_result;

    always_comb
    begin
        win_eff = win_len;
        if (win_len == '0)
        begin
            win_eff = WIN_W'(1);
        end
        else if (win_len > WIN_W'(WIN_CAP))
        begin
            win_eff = WIN_W'(WIN_CAP);
        end
    end

    assign over = (count_reg > {1'b0, win_eff});

    function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
        ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:     if (sq_valid) state_next = ST_WRITE;
            ST_WRITE:    state_next = ST_CHECK;
            ST_CHECK:    state_next = over ? ST_DROP_RD : ST_DIV;
            ST_DROP_RD:  state_next = ST_DROP_SUB;
            ST_DROP_SUB: state_next = ST_CHECK;
            ST_DIV:      if (div_stat.done) state_next = ST_DONE;
            ST_DONE:     if (!result_valid_reg || !result_stall) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // control strobes
    always_comb
    begin
        sq_pop      = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        div_start   = 1'b0;
        load_result = 1'b0;
        unique case (state_reg)
            ST_IDLE:     sq_pop = sq_valid;
            ST_WRITE:    ram_we = 1'b1;
            ST_CHECK:    div_start = !over;
            ST_DROP_RD:  ram_re = 1'b1;
            ST_DROP_SUB: ;
            ST_DIV:      ;
            ST_DONE:     load_result = !result_valid_reg || !result_stall;
            default:     ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            newest_reg       <= '0;
            oldest_reg       <= '0;
            count_reg        <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (ram_we)
            begin
                newest_reg <= ring_next(newest_reg);
                count_reg  <= count_reg + CNT_W'(1);
                sum_reg    <= sum_reg + SUM_W'(sq_reg);
            end
            if (state_reg == ST_DROP_SUB)
            begin
                oldest_reg <= ring_next(oldest_reg);
                count_reg  <= count_reg - CNT_W'(1);
                sum_reg    <= sum_reg - SUM_W'(ram_rdata);
            end
            if (load_result)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_pop)
        begin
            sq_reg <= sq_data;
        end
        if (load_result)
        begin
            mean_reg   <= MEAN_W'(quotient);
            vcount_reg <= count_reg[WIN_W-1:0];
        end
    end

    assign result_valid = result_valid_reg;
    assign avg_power    = mean_reg;
    assign valid_count  = vcount_reg;

    mms_ram #(
        .WIDTH (SQ_W),
        .DEPTH (DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (newest_reg),
        .wdata (sq_reg),
        .re    (ram_re),
        .raddr (oldest_reg),
        .rdata (ram_rdata)
    );

    mms_div #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (count_reg),
        .quotient (quotient),
        .status   (div_stat)
    );

    a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (count_reg <= CNT_W'(WIN_CAP)))
        else $error("entry count above window cap");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (count_reg != '0) && !over)
        else $error("divide started with bad count");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> div_stat.busy)
        else $error("waiting on idle divider");

    a_write_check: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_WRITE) |=> (state_reg == ST_CHECK) && (count_reg != '0))
        else $error("write not followed by window check");

endmodule

`default_nettype wire
